// File: rtl/core/gcmb_pkg.sv
// gcmb_pkg: shared constants, types and state encodings for the grid cell mean block
// used by gcmb_front, gcmb_queue, gcmb_back and grid_cell_mean_brightness
`default_nettype none

package gcmb_pkg;

  // frame and grid geometry
  localparam int FRAME_WIDTH  = 160;
  localparam int FRAME_HEIGHT = 120;
  localparam int GRID_COLUMNS = 8;
  localparam int GRID_ROWS    = 8;

  localparam int CELL_W = (FRAME_WIDTH / GRID_COLUMNS) > 0 ? (FRAME_WIDTH / GRID_COLUMNS) : 1;
  localparam int CELL_H = (FRAME_HEIGHT / GRID_ROWS) > 0 ? (FRAME_HEIGHT / GRID_ROWS) : 1;
  localparam int CELL_PIXELS = CELL_W * CELL_H;

  // field widths
  localparam int PIXEL_W = 8;
  localparam int INDEX_W = 6;
  localparam int MEAN_W  = 8;
  localparam int SUM_W   = 17;

  // counter widths
  localparam int X_W   = FRAME_WIDTH > 1 ? $clog2(FRAME_WIDTH) : 1;
  localparam int Y_W   = FRAME_HEIGHT > 1 ? $clog2(FRAME_HEIGHT) : 1;
  localparam int XIN_W = CELL_W > 1 ? $clog2(CELL_W) : 1;
  localparam int YIN_W = CELL_H > 1 ? $clog2(CELL_H) : 1;
  localparam int COL_W = GRID_COLUMNS > 1 ? $clog2(GRID_COLUMNS) : 1;
  localparam int ROW_W = GRID_ROWS > 1 ? $clog2(GRID_ROWS) : 1;

  localparam logic [X_W-1:0]   X_LAST   = X_W'(FRAME_WIDTH - 1);
  localparam logic [Y_W-1:0]   Y_LAST   = Y_W'(FRAME_HEIGHT - 1);
  localparam logic [XIN_W-1:0] XIN_LAST = XIN_W'(CELL_W - 1);
  localparam logic [YIN_W-1:0] YIN_LAST = YIN_W'(CELL_H - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);

  // mean by reciprocal multiply: floor(s / CELL_PIXELS) = (s * DIV_MULT) >> DIV_SHIFT,
  // exact for every 17-bit sum since SUM_MAX * rounding error stays below 2^DIV_SHIFT
  localparam int DIV_SHIFT = 26;
  localparam longint DIV_MULT_L = ((64'd1 << DIV_SHIFT) + CELL_PIXELS - 1) / CELL_PIXELS;
  localparam int MULT_W = $clog2(DIV_MULT_L + 1);
  localparam int PROD_W = SUM_W + MULT_W;
  localparam int QUOT_W = PROD_W - DIV_SHIFT;
  localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);
  localparam logic [QUOT_W-1:0] MEAN_MAX = QUOT_W'((1 << MEAN_W) - 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // one classified pixel
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               clear;
    logic               emit;
  } gcmb_item_t;

  typedef enum logic [1:0] {
    BK_ACCUM,
    BK_MUL,
    BK_OUT
  } gcmb_back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/gcmb_front.sv
// gcmb_front: pixel position tracking and classification into grid column, band and emit flag
// depends on gcmb_pkg
`default_nettype none

module gcmb_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        pixel_valid,
  output logic                             pixel_ready,
  input  wire logic [gcmb_pkg::PIXEL_W-1:0] pixel,
  input  wire logic                        frame_start,
  output logic                             push,
  output gcmb_pkg::gcmb_item_t             push_item,
  input  wire logic                        queue_full
);

  logic [gcmb_pkg::X_W-1:0]   x;
  logic [gcmb_pkg::Y_W-1:0]   y;
  logic [gcmb_pkg::XIN_W-1:0] xin;
  logic [gcmb_pkg::YIN_W-1:0] yin;
  logic [gcmb_pkg::COL_W-1:0] col;
  logic [gcmb_pkg::ROW_W-1:0] row;

  logic [gcmb_pkg::X_W-1:0]   x_cur;
  logic [gcmb_pkg::Y_W-1:0]   y_cur;
  logic [gcmb_pkg::XIN_W-1:0] xin_cur;
  logic [gcmb_pkg::YIN_W-1:0] yin_cur;
  logic [gcmb_pkg::COL_W-1:0] col_cur;
  logic [gcmb_pkg::ROW_W-1:0] row_cur;
  logic                       line_end;
  logic                       emit;

  // start of frame forces the position of this pixel to the origin
  always_comb begin
    x_cur   = frame_start ? '0 : x;
    y_cur   = frame_start ? '0 : y;
    xin_cur = frame_start ? '0 : xin;
    yin_cur = frame_start ? '0 : yin;
    col_cur = frame_start ? '0 : col;
    row_cur = frame_start ? '0 : row;
  end

  // band ends at the last line of a cell row, or at the frame's last line
  assign line_end = (x_cur == gcmb_pkg::X_LAST);
  assign emit = line_end && ((y_cur == gcmb_pkg::Y_LAST) ||
                ((row_cur != gcmb_pkg::ROW_LAST) && (yin_cur == gcmb_pkg::YIN_LAST)));

  assign pixel_ready = !queue_full;
  assign push        = pixel_valid && pixel_ready;

  always_comb begin
    push_item.pixel = pixel;
    push_item.col   = col_cur;
    push_item.row   = row_cur;
    push_item.clear = frame_start;
    push_item.emit  = emit;
  end

  // position counters, columns and rows clamp at the last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      x   <= '0;
      y   <= '0;
      xin <= '0;
      yin <= '0;
      col <= '0;
      row <= '0;
    end else if (push) begin
      if (line_end) begin
        x   <= '0;
        xin <= '0;
        col <= '0;
        if (y_cur == gcmb_pkg::Y_LAST) begin
          y   <= '0;
          yin <= '0;
          row <= '0;
        end else begin
          y <= y_cur + 1'b1;
          if (yin_cur == gcmb_pkg::YIN_LAST) begin
            yin <= '0;
            row <= (row_cur != gcmb_pkg::ROW_LAST) ? row_cur + 1'b1 : row_cur;
          end else begin
            yin <= yin_cur + 1'b1;
            row <= row_cur;
          end
        end
      end else begin
        x <= x_cur + 1'b1;
        y   <= y_cur;
        yin <= yin_cur;
        row <= row_cur;
        if (xin_cur == gcmb_pkg::XIN_LAST) begin
          xin <= '0;
          col <= (col_cur != gcmb_pkg::COL_LAST) ? col_cur + 1'b1 : col_cur;
        end else begin
          xin <= xin_cur + 1'b1;
          col <= col_cur;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gcmb_queue.sv
// gcmb_queue: small first-in first-out buffer of classified pixels between front and back
// depends on gcmb_pkg
`default_nettype none

module gcmb_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire gcmb_pkg::gcmb_item_t push_item,
  output logic                      full,
  input  wire logic                 pop,
  output gcmb_pkg::gcmb_item_t      head_item,
  output logic                      empty
);

  gcmb_pkg::gcmb_item_t          entries [gcmb_pkg::QUEUE_DEPTH];
  logic [gcmb_pkg::QPTR_W-1:0]   wr_ptr;
  logic [gcmb_pkg::QPTR_W-1:0]   rd_ptr;
  logic [gcmb_pkg::QPTR_W:0]     count;

  assign full      = (count == (gcmb_pkg::QPTR_W+1)'(gcmb_pkg::QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_item = entries[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gcmb_back.sv
// gcmb_back: per-column sum accumulation and band emission of cell means
// depends on gcmb_pkg
`default_nettype none

module gcmb_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire gcmb_pkg::gcmb_item_t         head_item,
  input  wire logic                         empty,
  output logic                              pop,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic [gcmb_pkg::INDEX_W-1:0]      cell_index,
  output logic [gcmb_pkg::MEAN_W-1:0]       cell_mean,
  output logic                              last_in_band
);

  gcmb_pkg::gcmb_back_state_t state;
  gcmb_pkg::gcmb_back_state_t state_next;

  logic [gcmb_pkg::SUM_W-1:0]  sums [gcmb_pkg::GRID_COLUMNS];
  logic [gcmb_pkg::COL_W-1:0]  idx;
  logic [gcmb_pkg::ROW_W-1:0]  band_row;
  logic [gcmb_pkg::PROD_W-1:0] prod;
  logic [gcmb_pkg::QUOT_W-1:0] quot;
  logic                        out_done;

  assign out_done = result_valid && result_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gcmb_pkg::BK_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    result_valid = 1'b0;
    unique case (state)
      gcmb_pkg::BK_ACCUM: begin
        pop = !empty;
        if (!empty && head_item.emit) begin
          state_next = gcmb_pkg::BK_MUL;
        end
      end
      gcmb_pkg::BK_MUL: begin
        state_next = gcmb_pkg::BK_OUT;
      end
      gcmb_pkg::BK_OUT: begin
        result_valid = 1'b1;
        if (result_ready) begin
          state_next = (idx == gcmb_pkg::COL_LAST) ? gcmb_pkg::BK_ACCUM : gcmb_pkg::BK_MUL;
        end
      end
      default: begin
        state_next = gcmb_pkg::BK_ACCUM;
      end
    endcase
  end

  // column sums: saturating accumulate, or shift toward the output during emission
  always_ff @(posedge clk) begin
    logic [gcmb_pkg::SUM_W-1:0] base;
    logic [gcmb_pkg::SUM_W:0]   wide;
    if (rst) begin
      for (int i = 0; i < gcmb_pkg::GRID_COLUMNS; i++) begin
        sums[i] <= '0;
      end
    end else if (pop) begin
      for (int i = 0; i < gcmb_pkg::GRID_COLUMNS; i++) begin
        base = head_item.clear ? '0 : sums[i];
        wide = {1'b0, base} + (gcmb_pkg::SUM_W+1)'(head_item.pixel);
        if (head_item.col == gcmb_pkg::COL_W'(i)) begin
          sums[i] <= wide[gcmb_pkg::SUM_W] ? '1 : wide[gcmb_pkg::SUM_W-1:0];
        end else begin
          sums[i] <= base;
        end
      end
    end else if (out_done) begin
      for (int i = 0; i < gcmb_pkg::GRID_COLUMNS - 1; i++) begin
        sums[i] <= sums[i+1];
      end
      sums[gcmb_pkg::GRID_COLUMNS-1] <= '0;
    end
  end

  // emission bookkeeping and the reciprocal product of the leading sum
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && head_item.emit) begin
      idx <= '0;
    end else if (out_done) begin
      idx <= (idx == gcmb_pkg::COL_LAST) ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.emit) begin
      band_row <= head_item.row;
    end
    if (state == gcmb_pkg::BK_MUL) begin
      prod <= gcmb_pkg::PROD_W'(sums[0]) * gcmb_pkg::PROD_W'(gcmb_pkg::DIV_MULT);
    end
  end

  // result fields
  assign quot         = prod[gcmb_pkg::PROD_W-1:gcmb_pkg::DIV_SHIFT];
  assign cell_mean    = (quot > gcmb_pkg::MEAN_MAX) ? '1 : quot[gcmb_pkg::MEAN_W-1:0];
  assign cell_index   = gcmb_pkg::INDEX_W'(int'(band_row) * gcmb_pkg::GRID_COLUMNS + int'(idx));
  assign last_in_band = (idx == gcmb_pkg::COL_LAST);

endmodule

`default_nettype wire

// File: rtl/core/grid_cell_mean_brightness.sv
// grid_cell_mean_brightness: top level, front classifier, queue and accumulate/emit back end
// depends on gcmb_pkg, gcmb_front, gcmb_queue, gcmb_back
`default_nettype none

// Takes 8-bit pixels of a 160x120 frame in raster order, one per transfer, and
// emits the mean brightness of each 20x15 grid cell as a band of eight results
// at the last pixel of every band of cell rows (the last band also takes any
// clamped lines). The front end tracks the pixel position and classifies each
// pixel combinationally, so pixels are taken at one per clock while the four-entry
// queue has room. The back end adds one pixel per clock into the column sums while
// the queue is not empty; a band emission holds it for each result through a
// reciprocal multiply and then an output transfer, plus any stall on the result
// side, during which the front keeps filling the queue.
// Sustained rate is one pixel per clock outside those emission windows.
// frame_start on a pixel restarts the position counters and clears the sums.

module grid_cell_mean_brightness (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        pixel_valid,
  output logic                             pixel_ready,
  input  wire logic [gcmb_pkg::PIXEL_W-1:0] pixel,
  input  wire logic                        frame_start,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic [gcmb_pkg::INDEX_W-1:0]     cell_index,
  output logic [gcmb_pkg::MEAN_W-1:0]      cell_mean,
  output logic                             last_in_band
);

  gcmb_pkg::gcmb_item_t push_item;
  gcmb_pkg::gcmb_item_t head_item;
  logic                 push;
  logic                 pop;
  logic                 queue_full;
  logic                 queue_empty;

  // position tracking and classification
  gcmb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .frame_start (frame_start),
    .push        (push),
    .push_item   (push_item),
    .queue_full  (queue_full)
  );

  // decoupling queue
  gcmb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head_item (head_item),
    .empty     (queue_empty)
  );

  // accumulation and band emission
  gcmb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_item    (head_item),
    .empty        (queue_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cell_index   (cell_index),
    .cell_mean    (cell_mean),
    .last_in_band (last_in_band)
  );

endmodule

`default_nettype wire
